/* design/lbfc_pkg.sv */
// Shared types and constants for the LED blink/fade controller.
package lbfc_pkg;

    localparam int ACTION_W = 3;
    localparam int LEVEL_W  = 8;
    localparam int MS_W     = 16;
    localparam int STEP_W   = 8;
    localparam int DUTY_W   = 8;
    localparam int MODE_W   = 3;

    // quotient of every division fits in DUTY_W bits, one bit per step
    localparam int DIV_STEPS = DUTY_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [DUTY_W-1:0]  FULL_MAX = 8'd255;
    localparam logic [LEVEL_W-1:0] PCT_MAX  = 8'd100;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK       = 3'd0,
        ACT_SET_VALUE  = 3'd1,
        ACT_ON         = 3'd2,
        ACT_OFF        = 3'd3,
        ACT_SET_BRIGHT = 3'd4,
        ACT_BLINK      = 3'd5,
        ACT_FADE_IN    = 3'd6,
        ACT_FADE_OUT   = 3'd7
    } action_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF       = 3'd0,
        MODE_ON        = 3'd1,
        MODE_BLINK_ON  = 3'd2,
        MODE_BLINK_OFF = 3'd3,
        MODE_FADE_IN   = 3'd4,
        MODE_FADE_OUT  = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic issue;     // request accepted: apply immediate update
        logic mul;       // load product into divider remainder
        logic div_step;  // one restoring division step
        logic finish;    // apply quotient
        logic load_out;  // move result into output registers
    } dp_cmd_t;

    typedef struct packed {
        logic need_div;  // request needs the multiply/divide path
    } dp_stat_t;

endpackage

/* design/lbfc_ctrl.sv */
// Sequencing state machine for the LED blink/fade controller.
module lbfc_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  lbfc_pkg::dp_stat_t stat,
    output lbfc_pkg::dp_cmd_t  cmd
);

    lbfc_pkg::state_t            state_reg, state_next;
    logic [lbfc_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lbfc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.need_div ? lbfc_pkg::ST_MUL : lbfc_pkg::ST_OUT;
                end
            end
            lbfc_pkg::ST_MUL:
            begin
                state_next = lbfc_pkg::ST_DIV;
            end
            lbfc_pkg::ST_DIV:
            begin
                if (cnt_reg == lbfc_pkg::CNT_W'(lbfc_pkg::DIV_STEPS - 1))
                begin
                    state_next = lbfc_pkg::ST_FIN;
                end
            end
            lbfc_pkg::ST_FIN:
            begin
                state_next = lbfc_pkg::ST_OUT;
            end
            lbfc_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = lbfc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lbfc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            lbfc_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.issue = in_valid;
            end
            lbfc_pkg::ST_MUL:
            begin
                cmd.mul  = 1'b1;
                cnt_next = '0;
            end
            lbfc_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
            end
            lbfc_pkg::ST_FIN:
            begin
                cmd.finish = 1'b1;
            end
            lbfc_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lbfc_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* design/lbfc_dp.sv */
// Datapath: mode/timer state, shared multiply and restoring divider, output registers.
module lbfc_dp
#(
    parameter int TIME_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lbfc_pkg::dp_cmd_t             cmd,
    output lbfc_pkg::dp_stat_t            stat,
    input  logic [lbfc_pkg::ACTION_W-1:0] action,
    input  logic [lbfc_pkg::LEVEL_W-1:0]  level,
    input  logic [lbfc_pkg::MS_W-1:0]     blink_on_ms,
    input  logic [lbfc_pkg::MS_W-1:0]     blink_off_ms,
    input  logic [lbfc_pkg::MS_W-1:0]     fade_ms,
    input  logic [lbfc_pkg::STEP_W-1:0]   fade_step_ms,
    output logic [lbfc_pkg::DUTY_W-1:0]   duty,
    output logic                          duty_written,
    output logic                          is_lit,
    output logic [lbfc_pkg::MODE_W-1:0]   mode
);

    localparam int PW = TIME_BITS + lbfc_pkg::DUTY_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [TIME_BITS-1:0] TIME_ONE = TIME_BITS'(1);

    typedef logic [TIME_BITS-1:0] tm_t;
    typedef logic [lbfc_pkg::DUTY_W-1:0] dt_t;

    // architectural state
    lbfc_pkg::mode_t mode_reg, mode_next;
    dt_t             full_reg, full_next;
    tm_t             elapsed_reg, elapsed_next;
    tm_t             lit_reg, lit_next;
    tm_t             dark_reg, dark_next;
    tm_t             fade_reg, fade_next;
    logic [lbfc_pkg::STEP_W-1:0] step_reg, step_next;
    logic [lbfc_pkg::STEP_W-1:0] scnt_reg, scnt_next;
    dt_t             duty_reg, duty_next;
    logic            written_reg, written_next;

    // divide path working registers
    lbfc_pkg::action_t act_reg, act_next;
    tm_t             opa_reg, opa_next;
    dt_t             opb_reg, opb_next;
    tm_t             dvs_reg, dvs_next;
    logic [PW-1:0]   rem_reg, rem_next;
    logic [PW-1:0]   dsh_reg, dsh_next;
    dt_t             quo_reg, quo_next;

    // output registers
    dt_t                          duty_o_reg;
    logic                         written_o_reg;
    logic                         lit_o_reg;
    logic [lbfc_pkg::MODE_W-1:0]  mode_o_reg;

    tm_t                         elapsed_inc;
    tm_t                         lit_min, dark_min;
    logic                        fade_done;
    logic [lbfc_pkg::STEP_W-1:0] step_min, scnt_inc;
    logic                        scnt_wrap;
    logic [lbfc_pkg::LEVEL_W-1:0] lvl_sat;
    logic                        need_div;

    function automatic tm_t sat_time(input logic [lbfc_pkg::MS_W-1:0] x);
        tm_t r;
        if ({17'd0, x} > 33'(TIME_MAX))
        begin
            r = TIME_MAX;
        end
        else
        begin
            r = TIME_BITS'(x);
        end
        return r;
    endfunction

    assign elapsed_inc = (elapsed_reg == TIME_MAX) ? elapsed_reg : elapsed_reg + TIME_ONE;
    assign lit_min     = (lit_reg == '0) ? TIME_ONE : lit_reg;
    assign dark_min    = (dark_reg == '0) ? TIME_ONE : dark_reg;
    assign fade_done   = elapsed_inc >= fade_reg;
    assign step_min    = (step_reg == '0) ? lbfc_pkg::STEP_W'(1) : step_reg;
    assign scnt_inc    = scnt_reg + 1'b1;
    // counter tracks elapsed mod step; elapsed is exact until the fade ends
    assign scnt_wrap   = scnt_inc == step_min;
    assign lvl_sat     = (level > lbfc_pkg::PCT_MAX) ? lbfc_pkg::PCT_MAX : level;

    always_comb
    begin
        mode_next    = mode_reg;
        full_next    = full_reg;
        elapsed_next = elapsed_reg;
        lit_next     = lit_reg;
        dark_next    = dark_reg;
        fade_next    = fade_reg;
        step_next    = step_reg;
        scnt_next    = scnt_reg;
        duty_next    = duty_reg;
        written_next = written_reg;
        act_next     = act_reg;
        opa_next     = opa_reg;
        opb_next     = opb_reg;
        dvs_next     = dvs_reg;
        rem_next     = rem_reg;
        dsh_next     = dsh_reg;
        quo_next     = quo_reg;
        need_div     = 1'b0;

        if (cmd.issue)
        begin
            act_next     = lbfc_pkg::action_t'(action);
            written_next = 1'b0;
            case (lbfc_pkg::action_t'(action))
                lbfc_pkg::ACT_TICK:
                begin
                    elapsed_next = elapsed_inc;
                    case (mode_reg)
                        lbfc_pkg::MODE_BLINK_ON:
                        begin
                            if (elapsed_inc >= lit_min)
                            begin
                                mode_next    = lbfc_pkg::MODE_BLINK_OFF;
                                elapsed_next = '0;
                                duty_next    = '0;
                                written_next = 1'b1;
                            end
                        end
                        lbfc_pkg::MODE_BLINK_OFF:
                        begin
                            if (elapsed_inc >= dark_min)
                            begin
                                mode_next    = lbfc_pkg::MODE_BLINK_ON;
                                elapsed_next = '0;
                                duty_next    = full_reg;
                                written_next = 1'b1;
                            end
                        end
                        lbfc_pkg::MODE_FADE_IN,
                        lbfc_pkg::MODE_FADE_OUT:
                        begin
                            scnt_next = scnt_wrap ? '0 : scnt_inc;
                            if (fade_done)
                            begin
                                written_next = 1'b1;
                                if (mode_reg == lbfc_pkg::MODE_FADE_IN)
                                begin
                                    duty_next = full_reg;
                                    mode_next = lbfc_pkg::MODE_ON;
                                end
                                else
                                begin
                                    duty_next = '0;
                                    mode_next = lbfc_pkg::MODE_OFF;
                                end
                            end
                            else if (scnt_wrap)
                            begin
                                written_next = 1'b1;
                                need_div     = 1'b1;
                                opa_next     = (mode_reg == lbfc_pkg::MODE_FADE_IN) ?
                                               elapsed_inc : fade_reg - elapsed_inc;
                                opb_next     = full_reg;
                                dvs_next     = fade_reg;
                            end
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
                lbfc_pkg::ACT_SET_VALUE:
                begin
                    written_next = 1'b1;
                    if (level == '0)
                    begin
                        mode_next = lbfc_pkg::MODE_OFF;
                        duty_next = '0;
                    end
                    else
                    begin
                        mode_next = lbfc_pkg::MODE_ON;
                        duty_next = full_reg;
                    end
                end
                lbfc_pkg::ACT_ON:
                begin
                    mode_next    = lbfc_pkg::MODE_ON;
                    duty_next    = full_reg;
                    written_next = 1'b1;
                end
                lbfc_pkg::ACT_OFF:
                begin
                    mode_next    = lbfc_pkg::MODE_OFF;
                    duty_next    = '0;
                    written_next = 1'b1;
                end
                lbfc_pkg::ACT_SET_BRIGHT:
                begin
                    // percent*255/100 through the shared divider
                    need_div = 1'b1;
                    opa_next = TIME_BITS'(lvl_sat);
                    opb_next = lbfc_pkg::FULL_MAX;
                    dvs_next = TIME_BITS'(lbfc_pkg::PCT_MAX);
                end
                lbfc_pkg::ACT_BLINK:
                begin
                    lit_next     = sat_time(blink_on_ms);
                    dark_next    = sat_time(blink_off_ms);
                    mode_next    = lbfc_pkg::MODE_BLINK_ON;
                    elapsed_next = '0;
                    duty_next    = full_reg;
                    written_next = 1'b1;
                end
                lbfc_pkg::ACT_FADE_IN,
                lbfc_pkg::ACT_FADE_OUT:
                begin
                    fade_next    = sat_time(fade_ms);
                    step_next    = fade_step_ms;
                    elapsed_next = '0;
                    scnt_next    = '0;
                    written_next = 1'b1;
                    if (lbfc_pkg::action_t'(action) == lbfc_pkg::ACT_FADE_IN)
                    begin
                        mode_next = lbfc_pkg::MODE_FADE_IN;
                        duty_next = '0;
                    end
                    else
                    begin
                        mode_next = lbfc_pkg::MODE_FADE_OUT;
                        duty_next = full_reg;
                    end
                end
                default:
                begin
                    written_next = 1'b0;
                end
            endcase
        end

        if (cmd.mul)
        begin
            rem_next = PW'(opa_reg) * PW'(opb_reg);
            dsh_next = PW'(dvs_reg) << (lbfc_pkg::DIV_STEPS - 1);
        end

        if (cmd.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                quo_next = {quo_reg[lbfc_pkg::DUTY_W-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[lbfc_pkg::DUTY_W-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
        end

        if (cmd.finish)
        begin
            if (act_reg == lbfc_pkg::ACT_SET_BRIGHT)
            begin
                full_next = quo_reg;
                if (mode_reg == lbfc_pkg::MODE_ON || mode_reg == lbfc_pkg::MODE_BLINK_ON)
                begin
                    duty_next    = quo_reg;
                    written_next = 1'b1;
                end
            end
            else
            begin
                duty_next = quo_reg;
                if (mode_reg == lbfc_pkg::MODE_FADE_IN && quo_reg == full_reg)
                begin
                    mode_next = lbfc_pkg::MODE_ON;
                end
                else if (mode_reg == lbfc_pkg::MODE_FADE_OUT && quo_reg == '0)
                begin
                    mode_next = lbfc_pkg::MODE_OFF;
                end
            end
        end
    end

    assign stat.need_div = need_div;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= lbfc_pkg::MODE_OFF;
            full_reg    <= lbfc_pkg::FULL_MAX;
            elapsed_reg <= '0;
            lit_reg     <= '0;
            dark_reg    <= '0;
            fade_reg    <= '0;
            step_reg    <= '0;
            scnt_reg    <= '0;
            duty_reg    <= '0;
            written_reg <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            full_reg    <= full_next;
            elapsed_reg <= elapsed_next;
            lit_reg     <= lit_next;
            dark_reg    <= dark_next;
            fade_reg    <= fade_next;
            step_reg    <= step_next;
            scnt_reg    <= scnt_next;
            duty_reg    <= duty_next;
            written_reg <= written_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
        if (cmd.load_out)
        begin
            duty_o_reg    <= duty_reg;
            written_o_reg <= written_reg;
            lit_o_reg     <= (mode_reg != lbfc_pkg::MODE_OFF) &&
                             (mode_reg != lbfc_pkg::MODE_BLINK_OFF);
            mode_o_reg    <= mode_reg;
        end
    end

    assign duty         = duty_o_reg;
    assign duty_written = written_o_reg;
    assign is_lit       = lit_o_reg;
    assign mode         = mode_o_reg;

endmodule

/* design/led_blink_fade_controller.sv */
// Top level of the LED blink/fade controller: state machine plus datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | action, level, blink_on_ms, blink_off_ms,
//          |                      | fade_ms, fade_step_ms
//  out     | out_valid / out_ready| duty, duty_written, is_lit, mode
//
// One request at a time. Ticks and commands that need no division go from accept
// straight to the output state. Fade steps and set_brightness go through a
// multiply step, an 8-step restoring divider and a finish step before output.
// A new request is accepted while the previous result still waits in the output
// register; a stalled output holds the following request in its last cycle.
// Reset (rst_n, async) puts the LED in the off mode with full level 255.
module led_blink_fade_controller
#(
    parameter int TIME_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lbfc_pkg::ACTION_W-1:0] action,
    input  logic [lbfc_pkg::LEVEL_W-1:0]  level,
    input  logic [lbfc_pkg::MS_W-1:0]     blink_on_ms,
    input  logic [lbfc_pkg::MS_W-1:0]     blink_off_ms,
    input  logic [lbfc_pkg::MS_W-1:0]     fade_ms,
    input  logic [lbfc_pkg::STEP_W-1:0]   fade_step_ms,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lbfc_pkg::DUTY_W-1:0]   duty,
    output logic                          duty_written,
    output logic                          is_lit,
    output logic [lbfc_pkg::MODE_W-1:0]   mode
);

    lbfc_pkg::dp_cmd_t  cmd;
    lbfc_pkg::dp_stat_t stat;

    lbfc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lbfc_dp
    #(
        .TIME_BITS (TIME_BITS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (action),
        .level        (level),
        .blink_on_ms  (blink_on_ms),
        .blink_off_ms (blink_off_ms),
        .fade_ms      (fade_ms),
        .fade_step_ms (fade_step_ms),
        .duty         (duty),
        .duty_written (duty_written),
        .is_lit       (is_lit),
        .mode         (mode)
    );

endmodule
